// File: rtl/bsg_pkg.sv
// shared types and constants of the bond segment geometry block
package bsg_pkg;

  localparam int unsigned AtomDepthDef = 256;
  localparam int unsigned IdxW         = 8;
  localparam int unsigned CoordW       = 32;
  localparam int unsigned DiffW        = 33;
  localparam int unsigned RadW         = 66;
  localparam int unsigned RemW         = 67;
  localparam int unsigned RootW        = 33;
  localparam int unsigned FracW        = 16;
  localparam int unsigned QuoW         = 17;
  localparam int unsigned DivRemW      = 50;
  localparam int unsigned UnitW        = 18;
  localparam logic [QuoW-1:0] UnitOne  = 17'd65536;

  localparam logic ActLoad = 1'b0;
  localparam logic ActBond = 1'b1;

  // endpoint coordinates and mid depth carried to the output
  typedef struct packed {
    logic signed [CoordW-1:0] sx;
    logic signed [CoordW-1:0] ex;
    logic signed [CoordW-1:0] sy;
    logic signed [CoordW-1:0] ey;
    logic signed [CoordW-1:0] mid;
  } geom_t;

  // sideband through the square root pipeline
  typedef struct packed {
    geom_t             geom;
    logic              neg_x;
    logic              neg_y;
    logic [DiffW-1:0]  mag_x;
    logic [DiffW-1:0]  mag_y;
  } sq_side_t;

  // sideband through the divider pipeline
  typedef struct packed {
    geom_t geom;
    logic  neg_x;
    logic  neg_y;
  } div_side_t;

endpackage

// File: rtl/bsg_ram.sv
// generic single write, single read ram with registered read data
module bsg_ram #(
  parameter int unsigned Width = 96,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bsg_sqrt.sv
// pipelined floor square root, one root bit per stage
module bsg_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [bsg_pkg::RadW-1:0]    rad_i,
  input  bsg_pkg::sq_side_t           side_i,
  output logic                        valid_o,
  output logic [bsg_pkg::RootW-1:0]   root_o,
  output bsg_pkg::sq_side_t           side_o
);

  localparam int unsigned Steps = bsg_pkg::RootW;

  logic                        stg_v    [Steps+1];
  logic [bsg_pkg::RemW-1:0]    stg_rem  [Steps+1];
  logic [bsg_pkg::RootW-1:0]   stg_root [Steps+1];
  bsg_pkg::sq_side_t           stg_side [Steps+1];

  assign stg_v[0]    = valid_i;
  assign stg_rem[0]  = bsg_pkg::RemW'(rad_i);
  assign stg_root[0] = '0;
  assign stg_side[0] = side_i;

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam int unsigned B = Steps - 1 - k;
    logic                      v_q;
    logic [bsg_pkg::RemW-1:0]  rem_q;
    logic [bsg_pkg::RootW-1:0] root_q;
    bsg_pkg::sq_side_t         side_q;
    logic [bsg_pkg::RemW-1:0]  trial;
    logic                      fits;

    // trial subtrahend for setting root bit B
    assign trial = (bsg_pkg::RemW'(stg_root[k]) << (B + 1))
                 | (bsg_pkg::RemW'(1) << (2 * B));
    assign fits  = (stg_rem[k] >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= stg_v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= fits ? (stg_rem[k] - trial) : stg_rem[k];
        root_q <= fits ? (stg_root[k] | (bsg_pkg::RootW'(1) << B)) : stg_root[k];
        side_q <= stg_side[k];
      end
    end

    assign stg_v[k+1]    = v_q;
    assign stg_rem[k+1]  = rem_q;
    assign stg_root[k+1] = root_q;
    assign stg_side[k+1] = side_q;
  end

  assign valid_o = stg_v[Steps];
  assign root_o  = stg_root[Steps];
  assign side_o  = stg_side[Steps];

endmodule

// File: rtl/bsg_div.sv
// pipelined restoring divider for both direction components, one quotient bit per stage
module bsg_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [bsg_pkg::DiffW-1:0]   mag_x_i,
  input  logic [bsg_pkg::DiffW-1:0]   mag_y_i,
  input  logic [bsg_pkg::RootW-1:0]   len_i,
  input  bsg_pkg::div_side_t          side_i,
  output logic                        valid_o,
  output logic [bsg_pkg::QuoW-1:0]    quo_x_o,
  output logic [bsg_pkg::QuoW-1:0]    quo_y_o,
  output logic [bsg_pkg::RootW-1:0]   len_o,
  output bsg_pkg::div_side_t          side_o
);

  localparam int unsigned Steps = bsg_pkg::QuoW;

  logic                          stg_v    [Steps+1];
  logic [bsg_pkg::DivRemW-1:0]   stg_rx   [Steps+1];
  logic [bsg_pkg::DivRemW-1:0]   stg_ry   [Steps+1];
  logic [bsg_pkg::QuoW-1:0]      stg_qx   [Steps+1];
  logic [bsg_pkg::QuoW-1:0]      stg_qy   [Steps+1];
  logic [bsg_pkg::RootW-1:0]     stg_len  [Steps+1];
  bsg_pkg::div_side_t            stg_side [Steps+1];

  // dividend is the magnitude scaled by the fraction width
  assign stg_v[0]    = valid_i;
  assign stg_rx[0]   = bsg_pkg::DivRemW'({mag_x_i, bsg_pkg::FracW'(0)});
  assign stg_ry[0]   = bsg_pkg::DivRemW'({mag_y_i, bsg_pkg::FracW'(0)});
  assign stg_qx[0]   = '0;
  assign stg_qy[0]   = '0;
  assign stg_len[0]  = len_i;
  assign stg_side[0] = side_i;

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam int unsigned B = Steps - 1 - k;
    logic                        v_q;
    logic [bsg_pkg::DivRemW-1:0] rx_q;
    logic [bsg_pkg::DivRemW-1:0] ry_q;
    logic [bsg_pkg::QuoW-1:0]    qx_q;
    logic [bsg_pkg::QuoW-1:0]    qy_q;
    logic [bsg_pkg::RootW-1:0]   len_q;
    bsg_pkg::div_side_t          side_q;
    logic [bsg_pkg::DivRemW-1:0] dsr;
    logic                        fx;
    logic                        fy;

    assign dsr = bsg_pkg::DivRemW'(stg_len[k]) << B;
    assign fx  = (stg_rx[k] >= dsr);
    assign fy  = (stg_ry[k] >= dsr);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= stg_v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q   <= fx ? (stg_rx[k] - dsr) : stg_rx[k];
        ry_q   <= fy ? (stg_ry[k] - dsr) : stg_ry[k];
        qx_q   <= fx ? (stg_qx[k] | (bsg_pkg::QuoW'(1) << B)) : stg_qx[k];
        qy_q   <= fy ? (stg_qy[k] | (bsg_pkg::QuoW'(1) << B)) : stg_qy[k];
        len_q  <= stg_len[k];
        side_q <= stg_side[k];
      end
    end

    assign stg_v[k+1]    = v_q;
    assign stg_rx[k+1]   = rx_q;
    assign stg_ry[k+1]   = ry_q;
    assign stg_qx[k+1]   = qx_q;
    assign stg_qy[k+1]   = qy_q;
    assign stg_len[k+1]  = len_q;
    assign stg_side[k+1] = side_q;
  end

  assign valid_o = stg_v[Steps];
  assign quo_x_o = stg_qx[Steps];
  assign quo_y_o = stg_qy[Steps];
  assign len_o   = stg_len[Steps];
  assign side_o  = stg_side[Steps];

endmodule

// File: rtl/bond_segment_geometry.sv
// bond segment geometry: bond items pass stages 0-3, square root, divider, output register
// one item per cycle unless held; the 33-stage square root and 17-stage divider set the depth
// the whole pipeline advances together and holds while the output register waits
// load items write the atom table and produce no result
// reset clears all valid bits; the atom table holds unknown data until written
module bond_segment_geometry #(
  parameter int unsigned ATOM_DEPTH = bsg_pkg::AtomDepthDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 action_i,
  input  logic [bsg_pkg::IdxW-1:0]             atom_index_i,
  input  logic signed [bsg_pkg::CoordW-1:0]    atom_x_i,
  input  logic signed [bsg_pkg::CoordW-1:0]    atom_y_i,
  input  logic signed [bsg_pkg::CoordW-1:0]    atom_z_i,
  input  logic [bsg_pkg::IdxW-1:0]             first_atom_i,
  input  logic [bsg_pkg::IdxW-1:0]             second_atom_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [bsg_pkg::CoordW-1:0]    start_x_o,
  output logic signed [bsg_pkg::CoordW-1:0]    end_x_o,
  output logic signed [bsg_pkg::CoordW-1:0]    start_y_o,
  output logic signed [bsg_pkg::CoordW-1:0]    end_y_o,
  output logic signed [bsg_pkg::CoordW-1:0]    mid_depth_o,
  output logic [bsg_pkg::RootW-1:0]            seg_length_o,
  output logic signed [bsg_pkg::UnitW-1:0]     unit_dx_o,
  output logic signed [bsg_pkg::UnitW-1:0]     unit_dy_o,
  output logic                                 zero_length_o
);

  localparam int unsigned AddrW  = $clog2(ATOM_DEPTH);
  localparam int unsigned EntryW = 3 * bsg_pkg::CoordW;
  localparam int unsigned CmpW   = 32;

  logic en;
  logic acc;

  // pipeline moves whenever the output register is free or being drained
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;
  assign acc        = in_valid_i && en;

  // table lookup
  logic             wr_ok;
  logic             oor_a;
  logic             oor_b;
  logic [EntryW-1:0] rd_a;
  logic [EntryW-1:0] rd_b;

  assign wr_ok = (CmpW'(atom_index_i) < CmpW'(ATOM_DEPTH));
  assign oor_a = (CmpW'(first_atom_i) >= CmpW'(ATOM_DEPTH));
  assign oor_b = (CmpW'(second_atom_i) >= CmpW'(ATOM_DEPTH));

  bsg_ram #(.Width(EntryW), .Depth(ATOM_DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (acc && (action_i == bsg_pkg::ActLoad) && wr_ok),
    .waddr_i (AddrW'(atom_index_i)),
    .wdata_i ({atom_x_i, atom_y_i, atom_z_i}),
    .re_i    (en),
    .raddr_i (AddrW'(first_atom_i)),
    .rdata_o (rd_a)
  );

  bsg_ram #(.Width(EntryW), .Depth(ATOM_DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (acc && (action_i == bsg_pkg::ActLoad) && wr_ok),
    .waddr_i (AddrW'(atom_index_i)),
    .wdata_i ({atom_x_i, atom_y_i, atom_z_i}),
    .re_i    (en),
    .raddr_i (AddrW'(second_atom_i)),
    .rdata_o (rd_b)
  );

  // stage 0: read issued
  logic v0_q;
  logic oor_a_q;
  logic oor_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= acc && (action_i == bsg_pkg::ActBond);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      oor_a_q <= oor_a;
      oor_b_q <= oor_b;
    end
  end

  // stage 1: differences, magnitudes and mid depth
  logic [EntryW-1:0]               ea;
  logic [EntryW-1:0]               eb;
  logic signed [bsg_pkg::CoordW-1:0] ax, ay, az, bx, by, bz;
  logic signed [bsg_pkg::DiffW-1:0]  dx, dy, zs;
  bsg_pkg::sq_side_t               s1_d;
  bsg_pkg::sq_side_t               s1_q;
  logic                            v1_q;

  assign ea = oor_a_q ? '0 : rd_a;
  assign eb = oor_b_q ? '0 : rd_b;
  assign {ax, ay, az} = ea;
  assign {bx, by, bz} = eb;
  assign dx = bsg_pkg::DiffW'(bx) - bsg_pkg::DiffW'(ax);
  assign dy = bsg_pkg::DiffW'(by) - bsg_pkg::DiffW'(ay);
  assign zs = bsg_pkg::DiffW'(az) + bsg_pkg::DiffW'(bz);

  always_comb begin
    s1_d.geom.sx  = ax;
    s1_d.geom.ex  = bx;
    s1_d.geom.sy  = ay;
    s1_d.geom.ey  = by;
    s1_d.geom.mid = zs[bsg_pkg::DiffW-1:1];
    s1_d.neg_x    = dx[bsg_pkg::DiffW-1];
    s1_d.neg_y    = dy[bsg_pkg::DiffW-1];
    s1_d.mag_x    = dx[bsg_pkg::DiffW-1] ? bsg_pkg::DiffW'(-dx) : bsg_pkg::DiffW'(dx);
    s1_d.mag_y    = dy[bsg_pkg::DiffW-1] ? bsg_pkg::DiffW'(-dy) : bsg_pkg::DiffW'(dy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
    end
  end

  // stage 2: squares
  logic                          v2_q;
  logic [bsg_pkg::RadW-1:0]      sqx_q;
  logic [bsg_pkg::RadW-1:0]      sqy_q;
  bsg_pkg::sq_side_t             s2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q <= bsg_pkg::RadW'(s1_q.mag_x) * bsg_pkg::RadW'(s1_q.mag_x);
      sqy_q <= bsg_pkg::RadW'(s1_q.mag_y) * bsg_pkg::RadW'(s1_q.mag_y);
      s2_q  <= s1_q;
    end
  end

  // stage 3: sum of squares
  logic                          v3_q;
  logic [bsg_pkg::RadW-1:0]      rad_q;
  bsg_pkg::sq_side_t             s3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q <= sqx_q + sqy_q;
      s3_q  <= s2_q;
    end
  end

  // square root pipeline
  logic                          sq_v;
  logic [bsg_pkg::RootW-1:0]     sq_root;
  bsg_pkg::sq_side_t             sq_side;
  bsg_pkg::div_side_t            dv_in_side;

  bsg_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .rad_i   (rad_q),
    .side_i  (s3_q),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  always_comb begin
    dv_in_side.geom  = sq_side.geom;
    dv_in_side.neg_x = sq_side.neg_x;
    dv_in_side.neg_y = sq_side.neg_y;
  end

  // divider pipeline
  logic                          dv_v;
  logic [bsg_pkg::QuoW-1:0]      qx;
  logic [bsg_pkg::QuoW-1:0]      qy;
  logic [bsg_pkg::RootW-1:0]     dv_len;
  bsg_pkg::div_side_t            dv_side;

  bsg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_v),
    .mag_x_i (sq_side.mag_x),
    .mag_y_i (sq_side.mag_y),
    .len_i   (sq_root),
    .side_i  (dv_in_side),
    .valid_o (dv_v),
    .quo_x_o (qx),
    .quo_y_o (qy),
    .len_o   (dv_len),
    .side_o  (dv_side)
  );

  // output stage: clamp, sign and zero length override
  logic                          zl;
  logic [bsg_pkg::QuoW-1:0]      cx;
  logic [bsg_pkg::QuoW-1:0]      cy;
  logic [bsg_pkg::UnitW-1:0]     ux_d;
  logic [bsg_pkg::UnitW-1:0]     uy_d;
  logic                          out_v_q;
  bsg_pkg::geom_t                geom_q;
  logic [bsg_pkg::RootW-1:0]     len_q;
  logic [bsg_pkg::UnitW-1:0]     ux_q;
  logic [bsg_pkg::UnitW-1:0]     uy_q;
  logic                          zl_q;

  assign zl = (dv_len == '0);
  assign cx = (qx > bsg_pkg::UnitOne) ? bsg_pkg::UnitOne : qx;
  assign cy = (qy > bsg_pkg::UnitOne) ? bsg_pkg::UnitOne : qy;

  always_comb begin
    ux_d = '0;
    uy_d = '0;
    if (!zl) begin
      ux_d = dv_side.neg_x ? bsg_pkg::UnitW'(-{1'b0, cx}) : {1'b0, cx};
      uy_d = dv_side.neg_y ? bsg_pkg::UnitW'(-{1'b0, cy}) : {1'b0, cy};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      geom_q <= dv_side.geom;
      len_q  <= dv_len;
      ux_q   <= ux_d;
      uy_q   <= uy_d;
      zl_q   <= zl;
    end
  end

  assign out_valid_o   = out_v_q;
  assign start_x_o     = geom_q.sx;
  assign end_x_o       = geom_q.ex;
  assign start_y_o     = geom_q.sy;
  assign end_y_o       = geom_q.ey;
  assign mid_depth_o   = geom_q.mid;
  assign seg_length_o  = len_q;
  assign unit_dx_o     = ux_q;
  assign unit_dy_o     = uy_q;
  assign zero_length_o = zl_q;

endmodule
